// ===== hdl/edws_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edws_pkg
// Shared constants, codes and controller/datapath bundles for the edit
// distance block.
// ---------------------------------------------------------------------------
package edws_pkg;

   // default maximum string length
   localparam int MAX_LEN_DEF = 64;

   // script limits
   localparam int MAX_OUT   = 64;
   localparam int OUT_DEPTH = MAX_OUT + 1;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);

   // stream widths
   localparam int CHAR_W  = 8;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int DIST_W  = 7;
   localparam int POS_W   = 6;
   localparam int RSP_DW  = 32;

   // request opcodes
   localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
   localparam logic [OP_W-1:0] OP_CAND  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMP  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // edit kinds (also the direction codes)
   localparam logic [KIND_W-1:0] K_INS  = 2'd0;
   localparam logic [KIND_W-1:0] K_DEL  = 2'd1;
   localparam logic [KIND_W-1:0] K_SUB  = 2'd2;
   localparam logic [KIND_W-1:0] K_NONE = 2'd3;

   // one stored edit
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] cc;
      logic [CHAR_W-1:0] kc;
      logic [KIND_W-1:0] kind;
   } edit_rec_type;

   localparam int EDIT_W = $bits(edit_rec_type);

   // controller to datapath commands
   typedef struct packed {
      logic acc_key;
      logic acc_cand;
      logic acc_clr;
      logic start;
      logic init_wr;
      logic row_start;
      logic cell_rd;
      logic cell_wr;
      logic row_end;
      logic dist_rd;
      logic dist_cap;
      logic tb_rd;
      logic tb_ev;
      logic emit_rd;
      logic emit_ld;
      logic emit_next;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic j_eq_lc;
      logic i_eq_lk;
      logic lc_zero;
      logic lk_zero;
      logic tb_done;
      logic out_free;
      logic emit_last;
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/edws_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edws_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module edws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/edws_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edws_ctrl
// Sequencer: loads characters, walks the table fill, the traceback and the
// script emission by issuing commands to the datapath.
// ---------------------------------------------------------------------------
module edws_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [edws_pkg::OP_W-1:0]     req_tuser,
   input  wire edws_pkg::sts_type             sts,
   output edws_pkg::cmd_type                  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INIT      = 4'd1;
   localparam logic [3:0] S_ROW_START = 4'd2;
   localparam logic [3:0] S_CELL_RD   = 4'd3;
   localparam logic [3:0] S_CELL_WR   = 4'd4;
   localparam logic [3:0] S_ROW_END   = 4'd5;
   localparam logic [3:0] S_DIST      = 4'd6;
   localparam logic [3:0] S_DCAP      = 4'd7;
   localparam logic [3:0] S_TB_RD     = 4'd8;
   localparam logic [3:0] S_TB_EV     = 4'd9;
   localparam logic [3:0] S_EMIT_RD   = 4'd10;
   localparam logic [3:0] S_EMIT_LD   = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  edws_pkg::OP_KEY:   cmd.acc_key  = 1'b1;
                  edws_pkg::OP_CAND:  cmd.acc_cand = 1'b1;
                  edws_pkg::OP_CLEAR: cmd.acc_clr  = 1'b1;
                  edws_pkg::OP_COMP: begin
                     cmd.start = 1'b1;
                     state_in  = S_INIT;
                  end
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.j_eq_lc) begin
               state_in = sts.lk_zero ? S_DIST : S_ROW_START;
            end
         end
         S_ROW_START: begin
            cmd.row_start = 1'b1;
            state_in = sts.lc_zero ? S_ROW_END : S_CELL_RD;
         end
         S_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in = S_CELL_WR;
         end
         S_CELL_WR: begin
            cmd.cell_wr = 1'b1;
            state_in = sts.j_eq_lc ? S_ROW_END : S_CELL_RD;
         end
         S_ROW_END: begin
            cmd.row_end = 1'b1;
            state_in = sts.i_eq_lk ? S_DIST : S_ROW_START;
         end
         S_DIST: begin
            cmd.dist_rd = 1'b1;
            state_in = S_DCAP;
         end
         S_DCAP: begin
            cmd.dist_cap = 1'b1;
            state_in = S_TB_RD;
         end
         S_TB_RD: begin
            if (sts.tb_done) begin
               state_in = S_EMIT_RD;
            end else begin
               cmd.tb_rd = 1'b1;
               state_in = S_TB_EV;
            end
         end
         S_TB_EV: begin
            cmd.tb_ev = 1'b1;
            state_in = S_TB_RD;
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in = S_EMIT_LD;
         end
         // load the result register once it is free
         S_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               if (sts.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/edws_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edws_dp
// Datapath: string stores, one score row, direction table, edit buffer,
// index counters, cell arithmetic and the result register.
// ---------------------------------------------------------------------------
module edws_dp #(
   parameter int MAX_LEN = edws_pkg::MAX_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire edws_pkg::cmd_type               cmd,
   output edws_pkg::sts_type                    sts,
   input  wire logic [edws_pkg::CHAR_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [edws_pkg::RSP_DW-1:0]     rsp_tdata,
   output logic      [edws_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DD  = MAX_LEN * MAX_LEN;
   localparam int DAW = (DD > 1) ? $clog2(DD) : 1;
   localparam int NW  = edws_pkg::OUT_AW;
   localparam int CW  = edws_pkg::CHAR_W;
   localparam int KW  = edws_pkg::KIND_W;

   localparam logic [LW-1:0]  ML_L = LW'(MAX_LEN);
   localparam logic [DAW-1:0] ML_D = DAW'(MAX_LEN);
   localparam logic [NW-1:0]  OUT_MAX = NW'(edws_pkg::MAX_OUT);
   localparam logic [NW-1:0]  OUT_DEP = NW'(edws_pkg::OUT_DEPTH);

   // control and counter registers
   logic [LW-1:0]  key_len_ff, key_len_in;
   logic [LW-1:0]  cand_len_ff, cand_len_in;
   logic           ovf_ff, ovf_in;
   logic [LW-1:0]  i_ff, i_in;
   logic [LW-1:0]  j_ff, j_in;
   logic [DAW-1:0] base_ff, base_in;
   logic [LW-1:0]  left_ff, left_in;
   logic [LW-1:0]  diag_ff, diag_in;
   logic [LW-1:0]  dist_ff, dist_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [5:0]     k_ff, k_in;
   logic           valid_ff, valid_in;
   logic           last_ff, last_in;
   logic [edws_pkg::RSP_DW-1:0] data_ff, data_in;
   logic [KW-1:0]  kind_ff, kind_in;

   // memory read data
   logic [CW-1:0]  key_rd;
   logic [CW-1:0]  cand_rd;
   logic [LW-1:0]  score_rd;
   logic [KW-1:0]  dir_rd;
   logic [edws_pkg::EDIT_W-1:0] edit_rd;

   // memory port controls
   logic           key_we, cand_we, score_we, key_re, cand_re, score_re;
   logic [AW-1:0]  key_ra;
   logic [LW-1:0]  score_wa, score_wd, score_ra;
   logic [DAW-1:0] dir_addr;
   logic           edit_we;
   logic [NW-1:0]  edit_ra;

   // derived values
   logic [LW-1:0]  im1, jm1, ip1;
   logic           key_full, cand_full;
   logic           mm;
   logic [LW:0]    del_c, ins_c, dia_c, best;
   logic [KW-1:0]  cell_dir;
   edws_pkg::edit_rec_type tb_rec;
   edws_pkg::edit_rec_type out_rec;
   logic [NW-1:0]  cnt;
   logic           emit_last;

   assign im1       = i_ff - 1'b1;
   assign jm1       = j_ff - 1'b1;
   assign ip1       = i_ff + 1'b1;
   assign key_full  = (key_len_ff == ML_L);
   assign cand_full = (cand_len_ff == ML_L);

   // cell minimum with deletion, insertion, diagonal tie order
   always_comb begin
      mm    = (key_rd != cand_rd);
      del_c = {1'b0, score_rd} + 1'b1;
      ins_c = {1'b0, left_ff} + 1'b1;
      dia_c = {1'b0, diag_ff} + {{LW{1'b0}}, mm};
      best  = del_c;
      if (ins_c < best) begin
         best = ins_c;
      end
      if (dia_c < best) begin
         best = dia_c;
      end
      if (best == del_c) begin
         cell_dir = edws_pkg::K_DEL;
      end else if (best == ins_c) begin
         cell_dir = edws_pkg::K_INS;
      end else begin
         cell_dir = mm ? edws_pkg::K_SUB : edws_pkg::K_NONE;
      end
   end

   // traceback step record
   always_comb begin
      tb_rec.kind = dir_rd;
      tb_rec.kc   = key_rd;
      tb_rec.cc   = cand_rd;
      tb_rec.pos  = 6'(im1);
      if (i_ff == '0) begin
         tb_rec.kind = edws_pkg::K_INS;
         tb_rec.kc   = '0;
         tb_rec.pos  = '0;
      end else if (j_ff == '0) begin
         tb_rec.kind = edws_pkg::K_DEL;
         tb_rec.cc   = '0;
      end else if (dir_rd == edws_pkg::K_DEL) begin
         tb_rec.cc   = '0;
      end else if (dir_rd == edws_pkg::K_INS) begin
         tb_rec.kc   = '0;
      end
   end

   // memory addressing
   always_comb begin
      key_we   = cmd.acc_key && !key_full;
      cand_we  = cmd.acc_cand && !cand_full;
      key_re   = cmd.row_start || cmd.tb_rd;
      key_ra   = cmd.row_start ? i_ff[AW-1:0] : im1[AW-1:0];
      cand_re  = cmd.cell_rd || cmd.tb_rd;
      score_we = cmd.init_wr || cmd.row_start || cmd.cell_wr;
      score_wa = cmd.row_start ? '0 : j_ff;
      if (cmd.init_wr) begin
         score_wd = j_ff;
      end else if (cmd.row_start) begin
         score_wd = ip1;
      end else begin
         score_wd = best[LW-1:0];
      end
      score_re = cmd.cell_rd || cmd.dist_rd;
      score_ra = cmd.dist_rd ? cand_len_ff : j_ff;
      dir_addr = base_ff + DAW'(jm1);
      edit_we  = cmd.tb_ev && (tb_rec.kind != edws_pkg::K_NONE) && (n_ff < OUT_DEP);
      edit_ra  = n_ff - 1'b1 - {1'b0, k_ff};
   end

   // result record and last flag
   always_comb begin
      out_rec = edit_rd;
      if (n_ff == '0) begin
         out_rec.kind = edws_pkg::K_NONE;
         out_rec.kc   = '0;
         out_rec.cc   = '0;
         out_rec.pos  = '0;
      end
      cnt       = (n_ff >= OUT_MAX) ? OUT_MAX : n_ff;
      emit_last = (n_ff == '0) || ({1'b0, k_ff} == cnt - 1'b1);
   end

   // next register values
   always_comb begin
      key_len_in  = key_len_ff;
      cand_len_in = cand_len_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      base_in     = base_ff;
      left_in     = left_ff;
      diag_in     = diag_ff;
      dist_in     = dist_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      valid_in    = valid_ff;
      last_in     = last_ff;
      data_in     = data_ff;
      kind_in     = kind_ff;

      // character loading
      if (cmd.acc_key) begin
         if (key_full) ovf_in = 1'b1;
         else          key_len_in = key_len_ff + 1'b1;
      end
      if (cmd.acc_cand) begin
         if (cand_full) ovf_in = 1'b1;
         else           cand_len_in = cand_len_ff + 1'b1;
      end
      if (cmd.acc_clr) begin
         key_len_in = '0;
         ovf_in     = 1'b0;
      end

      // table fill
      if (cmd.start) begin
         i_in    = '0;
         j_in    = '0;
         base_in = '0;
      end
      if (cmd.init_wr) begin
         j_in = j_ff + 1'b1;
      end
      if (cmd.row_start) begin
         i_in    = ip1;
         j_in    = {{(LW-1){1'b0}}, 1'b1};
         diag_in = i_ff;
         left_in = ip1;
      end
      if (cmd.cell_wr) begin
         left_in = best[LW-1:0];
         diag_in = score_rd;
         j_in    = j_ff + 1'b1;
      end
      if (cmd.row_end) begin
         base_in = base_ff + ML_D;
      end

      // traceback
      if (cmd.dist_rd) begin
         base_in = base_ff - ML_D;
         j_in    = cand_len_ff;
         n_in    = '0;
         k_in    = '0;
      end
      if (cmd.dist_cap) begin
         dist_in = score_rd;
      end
      if (cmd.tb_ev) begin
         if (edit_we) begin
            n_in = n_ff + 1'b1;
         end
         if (i_ff == '0) begin
            j_in = jm1;
         end else if (j_ff == '0 || dir_rd == edws_pkg::K_DEL) begin
            i_in    = im1;
            base_in = base_ff - ML_D;
         end else if (dir_rd == edws_pkg::K_INS) begin
            j_in = jm1;
         end else begin
            i_in    = im1;
            j_in    = jm1;
            base_in = base_ff - ML_D;
         end
      end

      // script emission, a taken result frees the register for the next load
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.emit_ld) begin
         valid_in = 1'b1;
         last_in  = emit_last;
         kind_in  = out_rec.kind;
         data_in  = {2'b00, ovf_ff, out_rec.pos, out_rec.cc, out_rec.kc, 7'(dist_ff)};
      end
      if (cmd.emit_next) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.finish) begin
         cand_len_in = '0;
         ovf_in      = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff  <= '0;
         cand_len_ff <= '0;
         ovf_ff      <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         key_len_ff  <= key_len_in;
         cand_len_ff <= cand_len_in;
         ovf_ff      <= ovf_in;
         valid_ff    <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      base_ff <= base_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      dist_ff <= dist_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      last_ff <= last_in;
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

   // status back to controller
   always_comb begin
      sts.j_eq_lc   = (j_ff == cand_len_ff);
      sts.i_eq_lk   = (i_ff == key_len_ff);
      sts.lc_zero   = (cand_len_ff == '0);
      sts.lk_zero   = (key_len_ff == '0);
      sts.tb_done   = (i_ff == '0) && (j_ff == '0);
      sts.out_free  = !valid_ff || rsp_tready;
      sts.emit_last = emit_last;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // key string store
   edws_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_len_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (key_re),
      .rd_addr (key_ra),
      .rd_data (key_rd)
   );

   // candidate string store
   edws_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_cand_ram (
      .clock   (clock),
      .wr_en   (cand_we),
      .wr_addr (cand_len_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (cand_re),
      .rd_addr (jm1[AW-1:0]),
      .rd_data (cand_rd)
   );

   // single score row, updated in place
   edws_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_score_ram (
      .clock   (clock),
      .wr_en   (score_we),
      .wr_addr (score_wa),
      .wr_data (score_wd),
      .rd_en   (score_re),
      .rd_addr (score_ra),
      .rd_data (score_rd)
   );

   // direction table
   edws_ram #(.WIDTH(KW), .DEPTH(DD)) u_dir_ram (
      .clock   (clock),
      .wr_en   (cmd.cell_wr),
      .wr_addr (dir_addr),
      .wr_data (cell_dir),
      .rd_en   (cmd.tb_rd),
      .rd_addr (dir_addr),
      .rd_data (dir_rd)
   );

   // edit buffer, filled backward, read forward
   edws_ram #(.WIDTH(edws_pkg::EDIT_W), .DEPTH(edws_pkg::OUT_DEPTH)) u_edit_ram (
      .clock   (clock),
      .wr_en   (edit_we),
      .wr_addr (n_ff),
      .wr_data (tb_rec),
      .rd_en   (cmd.emit_rd),
      .rd_addr (edit_ra),
      .rd_data (edit_rd)
   );

endmodule
`default_nettype wire

// ===== hdl/edit_distance_with_script.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edit_distance_with_script
// Levenshtein edit distance with forward edit script, table based.
// ---------------------------------------------------------------------------
// Requests carry an opcode in req_tuser: append key character, append
// candidate character, compute pair, clear key. Appends and clears leave the
// block idle and ready for the next request. A compute request fills the
// prefix distance table cell by cell (read, then write) through a single
// score row memory, traces back (at most lk+lc steps) and emits the script
// (read, then load per result), stalling while the result register still
// holds an edit that rsp_tready has not taken. New requests are accepted
// once the last result of the pair is loaded into the result register. The
// key is kept for further candidates; the candidate is cleared.
// ---------------------------------------------------------------------------
module edit_distance_with_script #(
   parameter int MAX_LEN = edws_pkg::MAX_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [edws_pkg::CHAR_W-1:0]     req_tdata,  // [7:0] character
   input  wire logic [edws_pkg::OP_W-1:0]       req_tuser,  // [1:0] opcode
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [6:0] distance, [14:7] key_char, [22:15] candidate_char,
   // [28:23] position, [29] overflow, [31:30] zero
   output logic      [edws_pkg::RSP_DW-1:0]     rsp_tdata,
   output logic      [edws_pkg::KIND_W-1:0]     rsp_tuser,  // [1:0] edit_kind
   output logic                                 rsp_tlast   // last
);

   edws_pkg::cmd_type cmd;
   edws_pkg::sts_type sts;

   // sequencer
   edws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and arithmetic
   edws_dp #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== sim/edws_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edws_checker
// Watches the request and result streams of the edit distance block, keeps
// its own copy of the key and candidate stores, and predicts the edit script
// for each compute request. It compares every result with the oldest
// expected edit.
// ---------------------------------------------------------------------------
module edws_checker #(
   parameter int LEN = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [edws_pkg::CHAR_W-1:0] req_tdata,
   input  wire logic [edws_pkg::OP_W-1:0]   req_tuser,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [edws_pkg::RSP_DW-1:0] rsp_tdata,
   input  wire logic [edws_pkg::KIND_W-1:0] rsp_tuser,
   input  wire logic                        rsp_tlast,
   output int                               failures,
   output int                               pending,
   output int                               results_seen
);

   typedef struct {
      logic [edws_pkg::DIST_W-1:0] distance;
      logic [edws_pkg::KIND_W-1:0] kind;
      logic [edws_pkg::CHAR_W-1:0] kc;
      logic [edws_pkg::CHAR_W-1:0] cc;
      logic [edws_pkg::POS_W-1:0]  pos;
      logic                        ovf;
      logic                        last;
   } script_edit_type;

   script_edit_type expected_edits[$];

   logic [edws_pkg::CHAR_W-1:0] key_chars [LEN];
   logic [edws_pkg::CHAR_W-1:0] cand_chars[LEN];
   logic [edws_pkg::KIND_W-1:0] trace_dir [LEN][LEN];
   int                          key_len;
   int                          cand_len;
   logic                        ovf_seen;

   assign pending = expected_edits.size();

   // fill the distance table, trace back, queue the script in forward order
   task automatic predict_script();
      int              prev_row[LEN+1];
      int              cur_row[LEN+1];
      int              i, j, del_c, ins_c, dia_c, best, pair_dist;
      logic            mis;
      script_edit_type e;
      script_edit_type script[$];
      for (j = 0; j <= cand_len; j++) prev_row[j] = j;
      for (i = 1; i <= key_len; i++) begin
         cur_row[0] = i;
         for (j = 1; j <= cand_len; j++) begin
            mis   = key_chars[i-1] != cand_chars[j-1];
            del_c = prev_row[j] + 1;
            ins_c = cur_row[j-1] + 1;
            dia_c = prev_row[j-1] + mis;
            best  = del_c;
            if (ins_c < best) best = ins_c;
            if (dia_c < best) best = dia_c;
            // ties prefer deletion, then insertion, then diagonal
            if (best == del_c)      trace_dir[i-1][j-1] = edws_pkg::K_DEL;
            else if (best == ins_c) trace_dir[i-1][j-1] = edws_pkg::K_INS;
            else trace_dir[i-1][j-1] = mis ? edws_pkg::K_SUB : edws_pkg::K_NONE;
            cur_row[j] = best;
         end
         prev_row = cur_row;
      end
      pair_dist = prev_row[cand_len];
      i = key_len;
      j = cand_len;
      while (i > 0 || j > 0) begin
         e.distance = pair_dist[edws_pkg::DIST_W-1:0];
         e.ovf      = ovf_seen;
         e.last     = 1'b0;
         if (i == 0) begin
            e.kind = edws_pkg::K_INS; e.kc = '0; e.cc = cand_chars[j-1]; e.pos = '0;
            j--;
         end else if (j == 0) begin
            e.kind = edws_pkg::K_DEL; e.kc = key_chars[i-1]; e.cc = '0;
            e.pos = edws_pkg::POS_W'(i - 1);
            i--;
         end else begin
            e.kind = trace_dir[i-1][j-1];
            e.pos  = edws_pkg::POS_W'(i - 1);
            e.kc   = key_chars[i-1];
            e.cc   = cand_chars[j-1];
            if (e.kind == edws_pkg::K_DEL) begin
               e.cc = '0; i--;
            end else if (e.kind == edws_pkg::K_INS) begin
               e.kc = '0; j--;
            end else begin
               i--; j--;
            end
         end
         if (e.kind != edws_pkg::K_NONE) script.push_front(e);
      end
      // equal strings give a single no-edit result
      if (script.size() == 0) begin
         e.distance = pair_dist[edws_pkg::DIST_W-1:0]; e.kind = edws_pkg::K_NONE;
         e.kc = '0; e.cc = '0; e.pos = '0; e.ovf = ovf_seen; e.last = 1'b0;
         script.push_back(e);
      end
      while (script.size() > edws_pkg::MAX_OUT) void'(script.pop_back());
      script[script.size()-1].last = 1'b1;
      foreach (script[k]) expected_edits.push_back(script[k]);
      cand_len = 0;
      ovf_seen = 1'b0;
   endtask

   // request side: update the predictor state
   always @(posedge clock) begin
      if (reset) begin
         key_len  = 0;
         cand_len = 0;
         ovf_seen = 1'b0;
      end else if (req_tvalid && req_tready) begin
         case (req_tuser)
            edws_pkg::OP_KEY: begin
               if (key_len < LEN) begin
                  key_chars[key_len] = req_tdata;
                  key_len = key_len + 1;
               end else ovf_seen = 1'b1;
            end
            edws_pkg::OP_CAND: begin
               if (cand_len < LEN) begin
                  cand_chars[cand_len] = req_tdata;
                  cand_len = cand_len + 1;
               end else ovf_seen = 1'b1;
            end
            edws_pkg::OP_COMP: predict_script();
            default: begin
               key_len  = 0;
               ovf_seen = 1'b0;
            end
         endcase
      end
   end

   // result side: compare with the oldest expected edit
   initial begin
      failures     = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      script_edit_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_edits.size() == 0) begin
            $error("unexpected result: tdata %h tuser %h", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            e = expected_edits.pop_front();
            if (rsp_tdata[6:0] !== e.distance) begin
               $error("distance: expected %0d, actual %0d", e.distance, rsp_tdata[6:0]);
               failures++;
            end
            if (rsp_tuser !== e.kind) begin
               $error("edit_kind: expected %0d, actual %0d", e.kind, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[14:7] !== e.kc) begin
               $error("key_char: expected %h, actual %h", e.kc, rsp_tdata[14:7]);
               failures++;
            end
            if (rsp_tdata[22:15] !== e.cc) begin
               $error("candidate_char: expected %h, actual %h", e.cc, rsp_tdata[22:15]);
               failures++;
            end
            if (rsp_tdata[28:23] !== e.pos) begin
               $error("position: expected %0d, actual %0d", e.pos, rsp_tdata[28:23]);
               failures++;
            end
            if (rsp_tdata[29] !== e.ovf) begin
               $error("overflow: expected %b, actual %b", e.ovf, rsp_tdata[29]);
               failures++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %b, actual %b", e.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives key, candidate, compute and clear requests into the edit distance
// block under changing back-pressure and lets the checker compare every
// edit of every script.
// ---------------------------------------------------------------------------
module testbench;

   localparam int LEN        = 64;
   localparam int ITEM_GOAL  = 410;
   localparam int STALL_MAX  = 200000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [edws_pkg::CHAR_W-1:0] req_tdata = '0;                 // [7:0] character
   logic [edws_pkg::OP_W-1:0]   req_tuser = edws_pkg::OP_KEY;   // [1:0] opcode
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // [6:0] distance, [14:7] key_char, [22:15] candidate_char,
   // [28:23] position, [29] overflow
   logic [edws_pkg::RSP_DW-1:0] rsp_tdata;
   logic [edws_pkg::KIND_W-1:0] rsp_tuser;                      // [1:0] edit_kind
   logic                        rsp_tlast;

   int failures, pending, results_seen;
   int tx_idle, rx_idle;
   int requests_sent, pairs_sent, quiet_cycles;

   always #2 clock = ~clock;

   edit_distance_with_script #(.MAX_LEN(LEN)) u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   edws_checker #(.LEN(LEN)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .failures, .pending, .results_seen
   );

   // result back-pressure
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle);

   // watchdog on cycles without any accepted request or result
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_MAX) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("testbench: FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // one request, with random gaps before it
   task automatic send_request(input logic [edws_pkg::OP_W-1:0]   op,
                               input logic [edws_pkg::CHAR_W-1:0] ch);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      requests_sent++;
      if (op == edws_pkg::OP_COMP) pairs_sent++;
   endtask

   function automatic logic [edws_pkg::CHAR_W-1:0] pick_char();
      // a small alphabet makes matches and ties common
      if ($urandom_range(1))
         return edws_pkg::CHAR_W'("a") + edws_pkg::CHAR_W'($urandom_range(2));
      return edws_pkg::CHAR_W'($urandom_range(255));
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(8);
      if (r < 96) return $urandom_range(LEN, 9);
      return $urandom_range(LEN + 3, LEN + 1);
   endfunction

   // a well formed pair, sometimes with a fresh key, sometimes with noise
   task automatic send_pair();
      int n;
      if ($urandom_range(99) < 35) begin
         send_request(edws_pkg::OP_CLEAR, edws_pkg::CHAR_W'($urandom_range(255)));
         n = pick_length();
         repeat (n) send_request(edws_pkg::OP_KEY, pick_char());
      end
      n = pick_length();
      repeat (n) send_request(edws_pkg::OP_CAND, pick_char());
      if ($urandom_range(99) < 8)
         send_request(edws_pkg::OP_W'($urandom_range(3)),
                      edws_pkg::CHAR_W'($urandom_range(255)));
      send_request(edws_pkg::OP_COMP, edws_pkg::CHAR_W'($urandom_range(255)));
   endtask

   initial begin
      quiet_cycles  = 0;
      requests_sent = 0;
      pairs_sent    = 0;
      tx_idle = 24;
      rx_idle = 51;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: both empty, key only, candidate only, extremes of bytes
      send_request(edws_pkg::OP_COMP, 8'hFF);
      send_request(edws_pkg::OP_KEY, 8'h00);
      send_request(edws_pkg::OP_KEY, 8'hFF);
      send_request(edws_pkg::OP_COMP, 8'h00);
      send_request(edws_pkg::OP_CAND, 8'hFF);
      send_request(edws_pkg::OP_CAND, 8'h00);
      send_request(edws_pkg::OP_COMP, 8'h5A);
      send_request(edws_pkg::OP_CAND, 8'h00);
      send_request(edws_pkg::OP_CAND, 8'hFF);
      send_request(edws_pkg::OP_COMP, 8'hA5);
      send_request(edws_pkg::OP_CAND, 8'h55);
      send_request(edws_pkg::OP_CAND, 8'hAA);
      send_request(edws_pkg::OP_CAND, 8'hFF);
      send_request(edws_pkg::OP_COMP, 8'h00);
      send_request(edws_pkg::OP_CLEAR, 8'hFF);
      send_request(edws_pkg::OP_CAND, 8'h61);
      send_request(edws_pkg::OP_CAND, 8'h62);
      send_request(edws_pkg::OP_COMP, 8'h00);
      send_request(edws_pkg::OP_KEY, 8'h61);
      send_request(edws_pkg::OP_CAND, 8'h61);
      send_request(edws_pkg::OP_COMP, 8'h00);

      // random pairs across three back-pressure phases
      while (requests_sent < ITEM_GOAL) begin
         if (requests_sent >= (2 * ITEM_GOAL) / 3) begin
            tx_idle = 0;  rx_idle = 0;
         end else if (requests_sent >= ITEM_GOAL / 3) begin
            tx_idle = 51; rx_idle = 24;
         end
         send_pair();
      end
      req_tvalid <= 1'b0;

      // drain, then a short tail
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d requests, %0d compute pairs, %0d script edits",
               requests_sent, pairs_sent, results_seen);
      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/edws_pkg.sv
hdl/edws_ram.sv
hdl/edws_ctrl.sv
hdl/edws_dp.sv
hdl/edit_distance_with_script.sv
sim/edws_checker.sv
sim/testbench.sv
